### design/irft_pkg.sv
package irft_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned HITS_W = 32;
	localparam int unsigned MAX_RANGES = 1024;
	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 8'd127;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_BUILD  = 2'd2,
		FUNC_LOOKUP = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_BUILT = 2'd2,
		ST_UNUSED    = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] range_start;
		logic [31:0] range_end;
		logic [7:0]  level_value;
		logic        use_default;
		logic [31:0] query_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        filtered;
		logic [9:0]  hit_index;
		logic [31:0] hit_total;
		logic [10:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  first;
		logic [ADDR_W-1:0]  last;
		logic [LEVEL_W-1:0] level;
		logic [HITS_W-1:0]  hits;
	} entry_t;

	typedef enum logic [4:0] {
		C_NOP,
		C_LATCH,
		C_CLEAR,
		C_APPEND,
		C_BUILD,
		C_SORT_RD,
		C_SORT_KEY,
		C_SORT_CMP,
		C_SORT_PLACE,
		C_MRG_RD,
		C_MRG_LOAD,
		C_MRG_STEP,
		C_MRG_FIN,
		C_LOOK,
		C_SRCH,
		C_SRCH_CMP,
		C_PROBE,
		C_EMIT
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       built;
		logic       lt2;
		logic       empty;
		logic       addr_zero;
		logic       sort_move;
		logic       j_one;
		logic       sort_last;
		logic       mrg_last;
		logic       srch_go;
		logic       lo_zero;
		logic       out_busy;
	} dp_status_t;

endpackage

### design/irft_ctrl.sv
module irft_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  irft_pkg::dp_status_t   st,
	output irft_pkg::cmd_t         cmd,
	output logic                   idle
);

	typedef enum logic [13:0] {
		S_IDLE       = 14'b00000000000001,
		S_DECODE     = 14'b00000000000010,
		S_SORT_RD    = 14'b00000000000100,
		S_SORT_KEY   = 14'b00000000001000,
		S_SORT_CMP   = 14'b00000000010000,
		S_SORT_PLACE = 14'b00000000100000,
		S_MRG_RD     = 14'b00000001000000,
		S_MRG_LOAD   = 14'b00000010000000,
		S_MRG_STEP   = 14'b00000100000000,
		S_MRG_FIN    = 14'b00001000000000,
		S_SRCH       = 14'b00010000000000,
		S_SRCH_CMP   = 14'b00100000000000,
		S_PROBE      = 14'b01000000000000,
		S_DONE       = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = irft_pkg::C_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd = irft_pkg::C_LATCH;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (irft_pkg::func_t'(st.func))
					irft_pkg::FUNC_CLEAR: begin
						cmd = irft_pkg::C_CLEAR;
						state_d = S_DONE;
					end
					irft_pkg::FUNC_APPEND: begin
						cmd = irft_pkg::C_APPEND;
						state_d = S_DONE;
					end
					irft_pkg::FUNC_BUILD: begin
						cmd = irft_pkg::C_BUILD;
						state_d = st.lt2 ? S_DONE : S_SORT_RD;
					end
					irft_pkg::FUNC_LOOKUP: begin
						cmd = irft_pkg::C_LOOK;
						state_d = (!st.built || st.empty || st.addr_zero) ? S_DONE : S_SRCH;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SORT_RD: begin
				cmd = irft_pkg::C_SORT_RD;
				state_d = S_SORT_KEY;
			end
			S_SORT_KEY: begin
				cmd = irft_pkg::C_SORT_KEY;
				state_d = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				cmd = irft_pkg::C_SORT_CMP;
				if (st.sort_move) begin
					state_d = st.j_one ? S_SORT_PLACE : S_SORT_CMP;
				end else begin
					state_d = st.sort_last ? S_MRG_RD : S_SORT_RD;
				end
			end
			S_SORT_PLACE: begin
				cmd = irft_pkg::C_SORT_PLACE;
				state_d = st.sort_last ? S_MRG_RD : S_SORT_RD;
			end
			S_MRG_RD: begin
				cmd = irft_pkg::C_MRG_RD;
				state_d = S_MRG_LOAD;
			end
			S_MRG_LOAD: begin
				cmd = irft_pkg::C_MRG_LOAD;
				state_d = S_MRG_STEP;
			end
			S_MRG_STEP: begin
				cmd = irft_pkg::C_MRG_STEP;
				state_d = st.mrg_last ? S_MRG_FIN : S_MRG_STEP;
			end
			S_MRG_FIN: begin
				cmd = irft_pkg::C_MRG_FIN;
				state_d = S_DONE;
			end
			S_SRCH: begin
				cmd = irft_pkg::C_SRCH;
				if (st.srch_go) begin
					state_d = S_SRCH_CMP;
				end else begin
					state_d = st.lo_zero ? S_DONE : S_PROBE;
				end
			end
			S_SRCH_CMP: begin
				cmd = irft_pkg::C_SRCH_CMP;
				state_d = S_SRCH;
			end
			S_PROBE: begin
				cmd = irft_pkg::C_PROBE;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd = irft_pkg::C_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/irft_datapath.sv
module irft_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  irft_pkg::cmd_t       cmd,
	input  irft_pkg::req_t       req,
	input  logic [7:0]           threshold,
	input  logic                 rsp_stall,
	output irft_pkg::dp_status_t st,
	output logic                 rsp_valid,
	output irft_pkg::rsp_t       rsp
);

	localparam int unsigned IDXW = (irft_pkg::MAX_RANGES > 1) ?
		$clog2(irft_pkg::MAX_RANGES) : 1;
	localparam int unsigned CNTW = $clog2(irft_pkg::MAX_RANGES + 1);

	irft_pkg::entry_t mem [irft_pkg::MAX_RANGES];
	irft_pkg::entry_t rd_q, key_q, cur_q, wr_data;
	logic             wr_en;
	logic [IDXW-1:0]  wr_addr, rd_addr;

	irft_pkg::req_t   req_q;
	logic [7:0]       thr_q;
	logic [CNTW-1:0]  count_q, i_q, j_q, w_q, r_q, lo_q, hi_q, mid_q;
	logic             built_q;
	logic [CNTW:0]    lo_hi_sum;
	logic [CNTW-1:0]  mid;
	logic [32:0]      cur_next;
	logic             overlap, adjacent, fold, match;
	logic [31:0]      hits_inc;

	logic [1:0]       res_status_q;
	logic             res_filt_q;
	logic [CNTW-1:0]  res_idx_q;
	logic [31:0]      res_tot_q;
	irft_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	assign lo_hi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = lo_hi_sum[CNTW:1];
	assign cur_next = {1'b0, cur_q.last} + 33'd1;
	assign overlap = (rd_q.first >= cur_q.first) && (rd_q.first <= cur_q.last);
	assign adjacent = ({1'b0, rd_q.first} == cur_next) && (rd_q.level == cur_q.level);
	assign fold = overlap || adjacent;
	assign match = (req_q.query_addr <= rd_q.last) && (rd_q.level < thr_q);
	assign hits_inc = (rd_q.hits == 32'hFFFF_FFFF) ? rd_q.hits : rd_q.hits + 32'd1;

	always_comb begin
		st.func = req_q.func;
		st.built = built_q;
		st.lt2 = (count_q < CNTW'(2));
		st.empty = (count_q == '0);
		st.addr_zero = (req_q.query_addr == 32'd0);
		st.sort_move = (rd_q.first > key_q.first);
		st.j_one = (j_q == CNTW'(1));
		st.sort_last = ({1'b0, i_q} + 1'b1 >= {1'b0, count_q});
		st.mrg_last = ({1'b0, r_q} + 1'b1 >= {1'b0, count_q});
		st.srch_go = (lo_q < hi_q);
		st.lo_zero = (lo_q == '0);
		st.out_busy = rsp_valid_q && rsp_stall;
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = j_q[IDXW-1:0];
		wr_data = key_q;
		rd_addr = i_q[IDXW-1:0];
		unique case (cmd)
			irft_pkg::C_APPEND: begin
				wr_en = (count_q < CNTW'(irft_pkg::MAX_RANGES));
				wr_addr = count_q[IDXW-1:0];
				wr_data = '{first: req_q.range_start, last: req_q.range_end,
					level: req_q.level_value, hits: 32'd0};
			end
			irft_pkg::C_SORT_RD: rd_addr = i_q[IDXW-1:0];
			irft_pkg::C_SORT_KEY: rd_addr = IDXW'(j_q - CNTW'(1));
			irft_pkg::C_SORT_CMP: begin
				wr_en = 1'b1;
				wr_data = st.sort_move ? rd_q : key_q;
				rd_addr = IDXW'(j_q - CNTW'(2));
			end
			irft_pkg::C_SORT_PLACE: wr_en = 1'b1;
			irft_pkg::C_MRG_RD: rd_addr = '0;
			irft_pkg::C_MRG_LOAD: rd_addr = IDXW'(1);
			irft_pkg::C_MRG_STEP: begin
				wr_en = !fold;
				wr_addr = w_q[IDXW-1:0];
				wr_data = cur_q;
				rd_addr = IDXW'(r_q + CNTW'(1));
			end
			irft_pkg::C_MRG_FIN: begin
				wr_en = 1'b1;
				wr_addr = w_q[IDXW-1:0];
				wr_data = cur_q;
			end
			irft_pkg::C_SRCH: rd_addr = st.srch_go ? mid[IDXW-1:0] : IDXW'(lo_q - CNTW'(1));
			irft_pkg::C_PROBE: begin
				wr_en = match;
				wr_addr = mid_q[IDXW-1:0];
				wr_data = rd_q;
				wr_data.hits = hits_inc;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// payload working registers
	always_ff @(posedge clk) begin
		unique case (cmd)
			irft_pkg::C_LATCH: begin
				req_q <= req;
				thr_q <= req.use_default ? threshold : req.level_value;
				res_filt_q <= 1'b0;
				res_idx_q <= '0;
				res_tot_q <= '0;
			end
			irft_pkg::C_SORT_RD: j_q <= i_q;
			irft_pkg::C_SORT_KEY: key_q <= rd_q;
			irft_pkg::C_SORT_CMP: if (st.sort_move) j_q <= j_q - CNTW'(1);
			irft_pkg::C_MRG_RD: w_q <= '0;
			irft_pkg::C_MRG_LOAD: begin
				cur_q <= rd_q;
				r_q <= CNTW'(1);
			end
			irft_pkg::C_MRG_STEP: begin
				r_q <= r_q + CNTW'(1);
				if (fold) begin
					if (rd_q.first != cur_q.first || rd_q.last != cur_q.last) begin
						if (rd_q.last > cur_q.last) cur_q.last <= rd_q.last;
					end else if (rd_q.level < cur_q.level) begin
						cur_q.level <= rd_q.level;
					end
				end else begin
					w_q <= w_q + CNTW'(1);
					cur_q <= rd_q;
				end
			end
			irft_pkg::C_LOOK: begin
				lo_q <= '0;
				hi_q <= count_q;
			end
			irft_pkg::C_SRCH: mid_q <= st.srch_go ? mid : lo_q - CNTW'(1);
			irft_pkg::C_SRCH_CMP: begin
				if (rd_q.first <= req_q.query_addr) lo_q <= mid_q + CNTW'(1);
				else hi_q <= mid_q;
			end
			irft_pkg::C_PROBE: begin
				if (match) begin
					res_filt_q <= 1'b1;
					res_idx_q <= mid_q;
					res_tot_q <= hits_inc;
				end
			end
			irft_pkg::C_EMIT: begin
				rsp_q <= '{status: res_status_q, filtered: res_filt_q,
					hit_index: 10'(res_idx_q), hit_total: res_tot_q,
					entry_count: 11'(count_q)};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			built_q <= 1'b0;
			i_q <= '0;
			res_status_q <= irft_pkg::ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd == irft_pkg::C_EMIT) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			unique case (cmd)
				irft_pkg::C_LATCH: res_status_q <= irft_pkg::ST_OK;
				irft_pkg::C_CLEAR: begin
					count_q <= '0;
					built_q <= 1'b0;
				end
				irft_pkg::C_APPEND: begin
					if (count_q < CNTW'(irft_pkg::MAX_RANGES)) begin
						count_q <= count_q + CNTW'(1);
						built_q <= 1'b0;
					end else begin
						res_status_q <= irft_pkg::ST_FULL;
					end
				end
				irft_pkg::C_BUILD: begin
					built_q <= 1'b1;
					i_q <= CNTW'(1);
				end
				irft_pkg::C_SORT_CMP: if (!st.sort_move) i_q <= i_q + CNTW'(1);
				irft_pkg::C_SORT_PLACE: i_q <= i_q + CNTW'(1);
				irft_pkg::C_MRG_FIN: count_q <= w_q + CNTW'(1);
				irft_pkg::C_LOOK: if (!built_q) res_status_q <= irft_pkg::ST_NOT_BUILT;
				default: ;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

### design/ip_range_filter_table.sv
// Clear and append go from decode straight to the result. Lookup runs a binary search, each
// step a read of the registered entry memory and then a compare, then probes the candidate entry if any.
// Build: insertion sort then merge on the single-port-pair entry memory.
// One item is worked at a time; a new item is taken while a result waits.
// Reset (arst_n low) empties the table, clears built and sets threshold to 127.
module ip_range_filter_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  irft_pkg::req_t    req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output irft_pkg::rsp_t    rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	irft_pkg::cmd_t       cmd;
	irft_pkg::dp_status_t st;
	logic                 idle;
	logic [7:0]           threshold_q;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {24'd0, threshold_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= irft_pkg::THRESHOLD_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			threshold_q <= pwdata[7:0];
		end
	end

	assign req_stall = !idle;

	irft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.st        (st),
		.cmd       (cmd),
		.idle      (idle)
	);

	irft_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.threshold (threshold_q),
		.rsp_stall (rsp_stall),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
